// ----- rtl/rti_pkg.sv -----
`timescale 1ns / 1ps
package rti_pkg;

	localparam int COORD_WIDTH      = 16;
	localparam int RESULT_FRAC_BITS = 16;
	localparam int FIELD_W          = 48;
	localparam int EPS_W            = 50;
	localparam int RES_W            = 32;
	localparam int APB_DW           = 64;
	localparam int PADDR_W          = 4;
	localparam int REG_IDX_BIT      = 3;
	localparam int REG_EPS          = 0;
	localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(16);

	localparam int DIFF_W    = COORD_WIDTH + 1;
	localparam int CROSS_W   = 2 * DIFF_W + 1;
	localparam int DOT_W     = DIFF_W + CROSS_W + 2;
	localparam int QBITS     = RES_W - 1;
	localparam int DIV_W     = DOT_W + QBITS;
	localparam int SAT_SHIFT = QBITS - RESULT_FRAC_BITS;
	localparam int CMP_W     = (DOT_W > EPS_W) ? DOT_W : EPS_W;

	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [CROSS_W-1:0] cross_t;
	typedef logic signed [DOT_W-1:0]   dot_t;

	typedef struct packed {
		diff_t x;
		diff_t y;
		diff_t z;
	} dvec_t;

	typedef struct packed {
		cross_t x;
		cross_t y;
		cross_t z;
	} cvec_t;

	typedef struct packed {
		dvec_t e1;
		dvec_t e2;
		dvec_t tv;
		dvec_t dir;
		cvec_t pv;
		cvec_t qv;
	} cross_item_t;

	typedef struct packed {
		logic                       hit;
		logic                       t_neg;
		logic                       t_sat;
		logic [DOT_W-1:0]           den;
		logic [2:0][DIV_W-1:0]      rem;
		logic [2:0][QBITS-1:0]      quo;
	} div_item_t;

	typedef struct packed {
		logic                    hit;
		logic signed [RES_W-1:0] distance;
		logic signed [RES_W-1:0] bary_u;
		logic signed [RES_W-1:0] bary_v;
	} result_t;

	function automatic diff_t coord(input logic [FIELD_W-1:0] w, input int k);
		logic [3*COORD_WIDTH+FIELD_W-1:0] ext;
		logic signed [COORD_WIDTH-1:0]    raw;
		diff_t                            r;
		ext = {{(3*COORD_WIDTH){1'b0}}, w};
		raw = ext[k*COORD_WIDTH +: COORD_WIDTH];
		r = DIFF_W'(raw);
		return r;
	endfunction

	function automatic dvec_t unpack(input logic [FIELD_W-1:0] w);
		dvec_t r;
		r.x = coord(w, 0);
		r.y = coord(w, 1);
		r.z = coord(w, 2);
		return r;
	endfunction

	function automatic dvec_t vsub(input dvec_t a, input dvec_t b);
		dvec_t r;
		r.x = a.x - b.x;
		r.y = a.y - b.y;
		r.z = a.z - b.z;
		return r;
	endfunction

	function automatic cvec_t cross3(input dvec_t a, input dvec_t b);
		cross_t p0, p1, p2, p3, p4, p5;
		cvec_t  r;
		p0 = a.y * b.z;
		p1 = a.z * b.y;
		p2 = a.z * b.x;
		p3 = a.x * b.z;
		p4 = a.x * b.y;
		p5 = a.y * b.x;
		r.x = p0 - p1;
		r.y = p2 - p3;
		r.z = p4 - p5;
		return r;
	endfunction

	function automatic dot_t dot(input dvec_t a, input cvec_t b);
		dot_t m0, m1, m2;
		m0 = a.x * b.x;
		m1 = a.y * b.y;
		m2 = a.z * b.z;
		return m0 + m1 + m2;
	endfunction

endpackage

// ----- rtl/rti_front.sv -----
`timescale 1ns / 1ps
module rti_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic [rti_pkg::FIELD_W-1:0]   ray_origin,
	input  logic [rti_pkg::FIELD_W-1:0]   ray_direction,
	input  logic [rti_pkg::FIELD_W-1:0]   corner_a,
	input  logic [rti_pkg::FIELD_W-1:0]   corner_b,
	input  logic [rti_pkg::FIELD_W-1:0]   corner_c,
	output logic                          valid_s2,
	output rti_pkg::cross_item_t          item_s2
);
	import rti_pkg::*;

	logic  valid_s1;
	dvec_t e1_s1, e2_s1, tv_s1, dir_s1;
	dvec_t org_c, dir_c, a_c, b_c, c_c;

	always_comb begin
		org_c = unpack(ray_origin);
		dir_c = unpack(ray_direction);
		a_c   = unpack(corner_a);
		b_c   = unpack(corner_b);
		c_c   = unpack(corner_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e1_s1       <= vsub(b_c, a_c);
			e2_s1       <= vsub(c_c, a_c);
			tv_s1       <= vsub(org_c, a_c);
			dir_s1      <= dir_c;
			item_s2.e1  <= e1_s1;
			item_s2.e2  <= e2_s1;
			item_s2.tv  <= tv_s1;
			item_s2.dir <= dir_s1;
			item_s2.pv  <= cross3(dir_s1, e2_s1);
			item_s2.qv  <= cross3(tv_s1, e1_s1);
		end
	end

endmodule

// ----- rtl/rti_dot.sv -----
`timescale 1ns / 1ps
module rti_dot (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        valid_s2,
	input  rti_pkg::cross_item_t        item_s2,
	input  logic [rti_pkg::EPS_W-1:0]   det_epsilon,
	output logic                        valid_s4,
	output rti_pkg::div_item_t          item_s4
);
	import rti_pkg::*;

	logic              valid_s3;
	dot_t              det_s3, un_s3, vn_s3, tn_s3;
	logic signed [DOT_W:0] uv_sum;
	logic [CMP_W-1:0]  det_cmp, eps_cmp;
	logic              det_ok, u_ok, v_ok;
	logic [DOT_W-1:0]  t_mag;
	logic [DIV_W-1:0]  sat_lim;
	div_item_t         item_c;

	always_comb begin
		uv_sum  = un_s3 + vn_s3;
		det_cmp = CMP_W'($unsigned(det_s3));
		eps_cmp = CMP_W'(det_epsilon);
		det_ok  = !det_s3[DOT_W-1] && (det_s3 != '0) && (det_cmp >= eps_cmp);
		u_ok    = !un_s3[DOT_W-1] && (un_s3 <= det_s3);
		v_ok    = !vn_s3[DOT_W-1] && (uv_sum <= det_s3);
		t_mag   = tn_s3[DOT_W-1] ? $unsigned(-tn_s3) : $unsigned(tn_s3);
		sat_lim = DIV_W'($unsigned(det_s3)) << SAT_SHIFT;

		item_c.hit    = det_ok && u_ok && v_ok;
		item_c.t_neg  = tn_s3[DOT_W-1];
		item_c.t_sat  = DIV_W'(t_mag) >= sat_lim;
		item_c.den    = $unsigned(det_s3);
		item_c.rem[0] = DIV_W'(t_mag) << RESULT_FRAC_BITS;
		item_c.rem[1] = DIV_W'($unsigned(un_s3)) << RESULT_FRAC_BITS;
		item_c.rem[2] = DIV_W'($unsigned(vn_s3)) << RESULT_FRAC_BITS;
		item_c.quo    = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s3  <= dot(item_s2.e1, item_s2.pv);
			un_s3   <= dot(item_s2.tv, item_s2.pv);
			vn_s3   <= dot(item_s2.dir, item_s2.qv);
			tn_s3   <= dot(item_s2.e2, item_s2.qv);
			item_s4 <= item_c;
		end
	end

endmodule

// ----- rtl/rti_divider.sv -----
`timescale 1ns / 1ps
module rti_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                valid_in,
	input  rti_pkg::div_item_t  item_in,
	output logic                valid_out,
	output rti_pkg::div_item_t  item_out
);
	import rti_pkg::*;

	div_item_t        stg_s [QBITS];
	logic [QBITS-1:0] stg_v_s;

	for (genvar j = 0; j < QBITS; j++) begin : g_stage
		div_item_t prev, nxt;
		logic      prev_v;

		if (j == 0) begin : g_first
			assign prev   = item_in;
			assign prev_v = valid_in;
		end else begin : g_next
			assign prev   = stg_s[j-1];
			assign prev_v = stg_v_s[j-1];
		end

		always_comb begin
			logic [DIV_W-1:0] cand;
			nxt  = prev;
			cand = DIV_W'(prev.den) << (QBITS - 1 - j);
			for (int k = 0; k < 3; k++) begin
				if (prev.rem[k] >= cand) begin
					nxt.rem[k] = prev.rem[k] - cand;
					nxt.quo[k][QBITS-1-j] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_v_s[j] <= 1'b0;
			end else if (adv) begin
				stg_v_s[j] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				stg_s[j] <= nxt;
			end
		end
	end

	assign valid_out = stg_v_s[QBITS-1];
	assign item_out  = stg_s[QBITS-1];

endmodule

// ----- rtl/ray_triangle_intersect_unit.sv -----
`timescale 1ns / 1ps
// Ray/triangle test with back faces culled, one word per cycle in and one per cycle out
// while neither side is stalled. Two stages form the edges and cross products, two form
// the dot products and the hit tests, and a 31-stage restoring divider resolves one
// quotient bit per stage for t, u and v in parallel, then a registered output. A skid
// register catches the divider's word when out_ready drops, so the input side keeps
// moving until the skid register is occupied; in_ready falls only while it is occupied.
// det_epsilon is at byte address 0 of the 64-bit configuration port.
module ray_triangle_intersect_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rti_pkg::PADDR_W-1:0]       paddr,
	input  logic [rti_pkg::APB_DW-1:0]        pwdata,
	output logic [rti_pkg::APB_DW-1:0]        prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rti_pkg::FIELD_W-1:0]       ray_origin,
	input  logic [rti_pkg::FIELD_W-1:0]       ray_direction,
	input  logic [rti_pkg::FIELD_W-1:0]       corner_a,
	input  logic [rti_pkg::FIELD_W-1:0]       corner_b,
	input  logic [rti_pkg::FIELD_W-1:0]       corner_c,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic signed [rti_pkg::RES_W-1:0]  distance,
	output logic signed [rti_pkg::RES_W-1:0]  bary_u,
	output logic signed [rti_pkg::RES_W-1:0]  bary_v
);
	import rti_pkg::*;

	localparam logic [RES_W-1:0] SAT_POS = {1'b0, {(RES_W-1){1'b1}}};
	localparam logic [RES_W-1:0] SAT_NEG = {1'b1, {(RES_W-1){1'b0}}};
	localparam logic [RES_W:0]   ONE_FX  = (RES_W+1)'(1) << RESULT_FRAC_BITS;

	logic [EPS_W-1:0] eps_q;
	logic             reg_is_eps;
	logic             adv;
	logic             valid_s2, valid_s4, div_valid;
	cross_item_t      item_s2;
	div_item_t        item_s4, div_item;
	result_t          res_c, out_q, skid_q;
	logic             out_valid_q, skid_valid_q;
	logic [RES_W-1:0] t_ext;

	assign pready     = 1'b1;
	assign reg_is_eps = (paddr[REG_IDX_BIT] == 1'(REG_EPS));
	assign prdata     = reg_is_eps ? {{(APB_DW-EPS_W){1'b0}}, eps_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (psel && penable && pwrite && pready && reg_is_eps) begin
			eps_q <= pwdata[EPS_W-1:0];
		end
	end

	assign adv      = !skid_valid_q;
	assign in_ready = adv;

	rti_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (in_valid),
		.ray_origin    (ray_origin),
		.ray_direction (ray_direction),
		.corner_a      (corner_a),
		.corner_b      (corner_b),
		.corner_c      (corner_c),
		.valid_s2      (valid_s2),
		.item_s2       (item_s2)
	);

	rti_dot u_dot (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.valid_s2    (valid_s2),
		.item_s2     (item_s2),
		.det_epsilon (eps_q),
		.valid_s4    (valid_s4),
		.item_s4     (item_s4)
	);

	rti_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_in  (valid_s4),
		.item_in   (item_s4),
		.valid_out (div_valid),
		.item_out  (div_item)
	);

	always_comb begin
		t_ext = {1'b0, div_item.quo[0]};
		res_c = '0;
		if (div_item.hit) begin
			res_c.hit = 1'b1;
			if (div_item.t_sat) begin
				res_c.distance = div_item.t_neg ? SAT_NEG : SAT_POS;
			end else begin
				res_c.distance = div_item.t_neg ? -t_ext : t_ext;
			end
			res_c.bary_u = {1'b0, div_item.quo[1]};
			res_c.bary_v = {1'b0, div_item.quo[2]};
		end
	end

	// hold the pipeline word in the skid register while the output stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= div_valid;
			end
		end else if (div_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : res_c;
		end else if (div_valid && !skid_valid_q) begin
			skid_q <= res_c;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = out_q.hit;
	assign distance  = out_q.distance;
	assign bary_u    = out_q.bary_u;
	assign bary_v    = out_q.bary_v;

	assert property (@(posedge clk) disable iff (!arst_n) skid_valid_q |-> out_valid_q)
		else $error("skid word without output word");

	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !out_ready |=> skid_valid_q)
		else $error("skid word dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> distance == '0 && bary_u == '0 && bary_v == '0)
		else $error("miss with nonzero result");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !bary_u[RES_W-1] && !bary_v[RES_W-1] &&
			(({1'b0, bary_u} + {1'b0, bary_v}) <= ONE_FX))
		else $error("barycentric coordinates outside triangle");

endmodule
